/* rtl/wind_speed_moving_average_assert.svh */
// ----------------------------------------------------------------------------
// Wind speed moving average: assertion macros
// Concurrent checks on clk, disabled while rst_n is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef WIND_SPEED_MOVING_AVERAGE_ASSERT_SVH
`define WIND_SPEED_MOVING_AVERAGE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define WSMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsma: same-cycle check failed");
// next-cycle implication
`define WSMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsma: next-cycle check failed");
`else
`define WSMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WSMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/wsma_pkg.sv */
// ----------------------------------------------------------------------------
// Wind speed moving average: package
// Window size, widths, unit scale factors and the reciprocal used for /W.
// ----------------------------------------------------------------------------
package wsma_pkg;

    localparam int unsigned WINDOW_LENGTH = 100;
    localparam int unsigned COUNT_W       = 8;
    localparam int unsigned COUNT_MAX     = (1 << COUNT_W) - 1;
    localparam int unsigned SLOT_W        = $clog2(WINDOW_LENGTH);
    localparam int unsigned SUM_MAX       = COUNT_MAX * WINDOW_LENGTH;
    localparam int unsigned SUM_W         = $clog2(SUM_MAX + 1);

    // speed = floor(sum * factor * 10 / WINDOW_LENGTH)
    localparam int unsigned TENTHS    = 10;
    localparam int unsigned NUM_UNITS = 4;
    localparam int unsigned UNIT_KNOTS = 0;
    localparam int unsigned UNIT_MPS   = 1;
    localparam int unsigned UNIT_KMPH  = 2;
    localparam int unsigned UNIT_MPH   = 3;
    localparam int unsigned UNIT_SCALE [NUM_UNITS] =
        '{22 * TENTHS, 11 * TENTHS, 41 * TENTHS, 25 * TENTHS};
    localparam int unsigned SCALE_MAX = 41 * TENTHS;

    localparam int unsigned X_W = $clog2(SUM_MAX * SCALE_MAX + 1);

    // floor(2^S / W); the quotient it gives is low by at most one
    localparam int unsigned RECIP_SHIFT = 32;
    localparam longint unsigned RECIP_MULT =
        (64'd1 << RECIP_SHIFT) / WINDOW_LENGTH;
    localparam int unsigned P_W = X_W + RECIP_SHIFT;

    localparam int unsigned KNOTS_W = 16;
    localparam int unsigned MPS_W   = 15;
    localparam int unsigned KMPH_W  = 17;
    localparam int unsigned MPH_W   = 16;
    localparam int unsigned OUT_W   = KNOTS_W + MPS_W + KMPH_W + MPH_W;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [X_W-1:0]     scaled_t;
    typedef logic [P_W-1:0]     prod_t;

    // pipeline stage handshake between ring and top
    typedef struct packed {
        logic   load;
        count_t count;
    } ring_wr_t;

endpackage

/* rtl/wsma_ring.sv */
// ----------------------------------------------------------------------------
// Wind speed moving average: count ring
// Holds the last WINDOW_LENGTH counts; returns the overwritten one in the cycle after the write.
// ----------------------------------------------------------------------------
module wsma_ring
(
    input  logic              clk,
    input  logic              rst_n,
    input  wsma_pkg::ring_wr_t wr,
    output wsma_pkg::count_t  old_count
);

    wsma_pkg::count_t mem [wsma_pkg::WINDOW_LENGTH];
    logic [wsma_pkg::WINDOW_LENGTH-1:0] valid_reg;
    wsma_pkg::slot_t  slot_reg;
    wsma_pkg::slot_t  slot_next;
    wsma_pkg::count_t rd_reg;
    logic             rd_valid_reg;

    // read-before-write: the read returns the count being replaced
    always_ff @(posedge clk)
    begin
        if (wr.load)
        begin
            rd_reg        <= mem[slot_reg];
            mem[slot_reg] <= wr.count;
        end
    end

    always_comb
    begin
        if (slot_reg == wsma_pkg::slot_t'(wsma_pkg::WINDOW_LENGTH - 1))
            slot_next = '0;
        else
            slot_next = slot_reg + wsma_pkg::slot_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= '0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else if (wr.load)
        begin
            slot_reg            <= slot_next;
            valid_reg[slot_reg] <= 1'b1;
            rd_valid_reg        <= valid_reg[slot_reg];
        end
    end

    // an entry never written is not reset in memory; its clear valid bit makes it read as zero
    assign old_count = rd_valid_reg ? rd_reg : '0;

endmodule

/* rtl/wind_speed_moving_average.sv */
// ----------------------------------------------------------------------------
// Wind speed moving average: boxcar average of pulse counts, four speed units
// Throughput: one word per cycle unless m_tready stalls the output, set by the single-port ring read/write.
// Stages, in order: ring read, sum update, scale multiply, reciprocal multiply,
// and quotient correction into the output register that drives m_tvalid.
// Reset clears the ring (per-entry valid bits), slot pointer, sum and stage valids.
// ----------------------------------------------------------------------------
`include "wind_speed_moving_average_assert.svh"

module wind_speed_moving_average
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pulse_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [15:0] speed_knots_tenths,
                                   // [30:16] speed_mps_tenths,
                                   // [47:31] speed_kmph_tenths,
                                   // [63:48] speed_mph_tenths
);

    localparam int unsigned NU = wsma_pkg::NUM_UNITS;

    // stage valids: 1 ring read, 2 sum, 3 scaled, 4 product, o output
    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic ld1, ld2, ld3, ld4, ldo;
    logic free1, free2, free3, free4, freeo;

    wsma_pkg::ring_wr_t ring_wr;
    wsma_pkg::count_t   old_count;
    wsma_pkg::count_t   new_reg;
    wsma_pkg::sum_t     sum_reg;
    wsma_pkg::sum_t     sum_next;

    wsma_pkg::scaled_t x_reg  [NU];
    wsma_pkg::scaled_t xp_reg [NU];
    wsma_pkg::prod_t   p_reg  [NU];
    wsma_pkg::scaled_t q      [NU];
    logic [wsma_pkg::OUT_W-1:0] out_reg;

    // advance a stage when the one after it is empty or moving on
    assign freeo = !vo_reg || m_tready;
    assign ldo   = v4_reg && freeo;
    assign free4 = !v4_reg || ldo;
    assign ld4   = v3_reg && free4;
    assign free3 = !v3_reg || ld4;
    assign ld3   = v2_reg && free3;
    assign free2 = !v2_reg || ld3;
    assign ld2   = v1_reg && free2;
    assign free1 = !v1_reg || ld2;
    assign ld1   = s_tvalid && free1;

    assign s_tready = free1;
    assign m_tvalid = vo_reg;
    assign m_tdata  = out_reg;

    assign ring_wr.load  = ld1;
    assign ring_wr.count = s_tdata;

    wsma_ring u_ring
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (ring_wr),
        .old_count (old_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
                v1_reg <= 1'b1;
            else if (ld2)
                v1_reg <= 1'b0;
            if (ld2)
                v2_reg <= 1'b1;
            else if (ld3)
                v2_reg <= 1'b0;
            if (ld3)
                v3_reg <= 1'b1;
            else if (ld4)
                v3_reg <= 1'b0;
            if (ld4)
                v4_reg <= 1'b1;
            else if (ldo)
                v4_reg <= 1'b0;
            if (ldo)
                vo_reg <= 1'b1;
            else if (m_tready)
                vo_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
            new_reg <= s_tdata;
    end

    // old count is part of the sum, so the difference never goes negative
    assign sum_next = wsma_pkg::SUM_W'(({1'b0, sum_reg} + (wsma_pkg::SUM_W+1)'(new_reg))
                                       - (wsma_pkg::SUM_W+1)'(old_count));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (ld2)
            sum_reg <= sum_next;
    end

    for (genvar k = 0; k < NU; k++)
    begin : g_unit
        wsma_pkg::scaled_t q0;
        wsma_pkg::scaled_t rem;

        always_ff @(posedge clk)
        begin
            if (ld3)
                x_reg[k] <= wsma_pkg::X_W'(32'(sum_reg) * wsma_pkg::UNIT_SCALE[k]);
            if (ld4)
            begin
                p_reg[k]  <= wsma_pkg::P_W'(x_reg[k])
                             * wsma_pkg::P_W'(wsma_pkg::RECIP_MULT);
                xp_reg[k] <= x_reg[k];
            end
        end

        // estimate is exact or one low; fix up with the remainder
        assign q0  = p_reg[k][wsma_pkg::P_W-1:wsma_pkg::RECIP_SHIFT];
        assign rem = xp_reg[k]
                     - wsma_pkg::X_W'(q0 * wsma_pkg::X_W'(wsma_pkg::WINDOW_LENGTH));
        assign q[k] = (rem >= wsma_pkg::X_W'(wsma_pkg::WINDOW_LENGTH))
                      ? q0 + wsma_pkg::X_W'(1) : q0;
    end

    always_ff @(posedge clk)
    begin
        if (ldo)
            out_reg <= {wsma_pkg::MPH_W'(q[wsma_pkg::UNIT_MPH]),
                        wsma_pkg::KMPH_W'(q[wsma_pkg::UNIT_KMPH]),
                        wsma_pkg::MPS_W'(q[wsma_pkg::UNIT_MPS]),
                        wsma_pkg::KNOTS_W'(q[wsma_pkg::UNIT_KNOTS])};
    end

    `WSMA_ASSERT_IMP(a_sum_range, clk, rst_n, 1'b1, sum_reg <= wsma_pkg::SUM_W'(wsma_pkg::SUM_MAX))
    `WSMA_ASSERT_NXT(a_accept_fills, clk, rst_n, s_tvalid && s_tready, v1_reg)
    `WSMA_ASSERT_NXT(a_stall_holds, clk, rst_n, v4_reg && vo_reg && !m_tready, v4_reg && vo_reg)

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wind speed moving average: self-checking testbench
// Streams pulse counts into the block and predicts the four averaged speeds
// from its own copy of the count ring and running sum. Covers the extreme
// counts, warm-up after reset, full-scale windows, runs of zeros, and slot
// wraparound. Input and output idle at random, and one long output stall
// backs the block up.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned PIPE_LATENCY = 4;

    typedef struct {
        logic [wsma_pkg::KNOTS_W-1:0] knots;
        logic [wsma_pkg::MPS_W-1:0]   mps;
        logic [wsma_pkg::KMPH_W-1:0]  kmph;
        logic [wsma_pkg::MPH_W-1:0]   mph;
    } speeds_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] pulse_count
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [15:0] knots, [30:16] m/s, [47:31] km/h, [63:48] mph

    // predictor state
    wsma_pkg::count_t count_hist [wsma_pkg::WINDOW_LENGTH];
    int unsigned      next_slot;
    int unsigned      window_sum;

    speeds_t     pending_speeds [$];
    int unsigned counts_sent;
    int unsigned speeds_checked;
    int unsigned mismatches;
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned hold_request;
    int unsigned hold_left;
    int unsigned full_windows;

    wind_speed_moving_average dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned scaled_speed(input int unsigned unit);
        return (longint'(window_sum) * wsma_pkg::UNIT_SCALE[unit])
               / wsma_pkg::WINDOW_LENGTH;
    endfunction

    // replace the oldest count and return the averaged speeds
    function automatic speeds_t advance_average(input wsma_pkg::count_t c);
        speeds_t s;
        window_sum = window_sum + 32'(c) - 32'(count_hist[next_slot]);
        count_hist[next_slot] = c;
        next_slot = (next_slot == wsma_pkg::WINDOW_LENGTH - 1) ? 0 : next_slot + 1;
        if (window_sum == wsma_pkg::SUM_MAX)
            full_windows++;
        s.knots = wsma_pkg::KNOTS_W'(scaled_speed(wsma_pkg::UNIT_KNOTS));
        s.mps   = wsma_pkg::MPS_W'(scaled_speed(wsma_pkg::UNIT_MPS));
        s.kmph  = wsma_pkg::KMPH_W'(scaled_speed(wsma_pkg::UNIT_KMPH));
        s.mph   = wsma_pkg::MPH_W'(scaled_speed(wsma_pkg::UNIT_MPH));
        return s;
    endfunction

    task automatic send_count(input wsma_pkg::count_t c);
        // draw each idle cycle separately so the idle share tracks the percentage
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do
            @(posedge clk);
        while (!s_tready);
        pending_speeds.push_back(advance_average(c));
        counts_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_speeds.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string label, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch on word %0d: expected %0d, got %0d",
                         $realtime, label, speeds_checked, want, got);
        end
    endtask

    // compare each accepted word against the oldest prediction
    always @(posedge clk)
    begin
        speeds_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_speeds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected output word %h", $realtime, m_tdata);
            end
            else
            begin
                want = pending_speeds.pop_front();
                check_field("knots", 32'(want.knots), 32'(m_tdata[15:0]));
                check_field("m/s",   32'(want.mps),   32'(m_tdata[30:16]));
                check_field("km/h",  32'(want.kmph),  32'(m_tdata[47:31]));
                check_field("mph",   32'(want.mph),   32'(m_tdata[63:48]));
            end
            speeds_checked++;
        end
    end

    // output ready: random idling, or a counted hold-off on request
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic test_directed();
        wsma_pkg::count_t pattern [$];
        pattern = {8'd0, 8'd255, 8'd255, 8'd0, 8'd1, 8'd2, 8'd4, 8'd8, 8'd16,
                   8'd32, 8'd64, 8'd128, 8'd254, 8'd253, 8'd251, 8'd247,
                   8'd239, 8'd223, 8'd191, 8'd127, 8'd170, 8'd85, 8'd255, 8'd0};
        foreach (pattern[i])
            send_count(pattern[i]);
        wait_drained();
    endtask

    // bursts: full-scale windows, zero runs of up to a window, plus high, low and uniform counts
    task automatic test_random(input int unsigned n, input int unsigned src_pct,
                               input int unsigned sink_pct);
        int unsigned      left;
        int unsigned      len;
        int unsigned      mode;
        wsma_pkg::count_t c;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        left = n;
        while (left != 0)
        begin
            mode = $urandom_range(7);
            case (mode)
                0:       len = wsma_pkg::WINDOW_LENGTH + $urandom_range(30);
                1:       len = $urandom_range(10, wsma_pkg::WINDOW_LENGTH);
                default: len = $urandom_range(5, 50);
            endcase
            if (len > left)
                len = left;
            repeat (len)
            begin
                case (mode)
                    0:       c = wsma_pkg::COUNT_W'(wsma_pkg::COUNT_MAX);
                    1:       c = '0;
                    2, 3:    c = wsma_pkg::COUNT_W'($urandom_range(200, wsma_pkg::COUNT_MAX));
                    4, 5:    c = wsma_pkg::COUNT_W'($urandom_range(wsma_pkg::COUNT_MAX));
                    default: c = wsma_pkg::COUNT_W'($urandom_range(15));
                endcase
                send_count(c);
            end
            left -= len;
        end
        wait_drained();
    endtask

    // stall the output long enough that the input backs up
    task automatic test_output_stall();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_request  = 300;
        repeat (50)
            send_count(wsma_pkg::COUNT_W'($urandom_range(wsma_pkg::COUNT_MAX)));
        wait_drained();
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        next_slot      = 0;
        window_sum     = 0;
        counts_sent    = 0;
        speeds_checked = 0;
        mismatches     = 0;
        full_windows   = 0;
        hold_request   = 0;
        hold_left      = 0;
        src_idle_pct   = 12;
        sink_idle_pct  = 68;
        foreach (count_hist[i])
            count_hist[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(650, 12, 68);
        test_random(650, 68, 12);
        test_output_stall();
        test_random(600, 0, 0);

        repeat (4 * PIPE_LATENCY) @(posedge clk);
        mismatches += pending_speeds.size();

        $display("Streamed %0d pulse counts, checked %0d speed words", counts_sent,
                 speeds_checked);
        $display("Full-scale window reached %0d times, ring wrapped %0d times",
                 full_windows, counts_sent / wsma_pkg::WINDOW_LENGTH);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d speed words outstanding", pending_speeds.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* wind_speed_moving_average.f */
+incdir+rtl
rtl/wsma_pkg.sv
rtl/wsma_ring.sv
rtl/wind_speed_moving_average.sv
tb/sv/tb.sv
